// File: hw/rtl/sws_pkg.sv
package sws_pkg;

  // Joystick codes
  localparam logic [4:0] JOY_CENTRE = 5'd16;
  localparam logic [4:0] JOY_LEFT   = 5'd4;
  localparam logic [4:0] JOY_RIGHT  = 5'd8;
  localparam logic [4:0] JOY_DOWN   = 5'd2;

  // Split report codes
  localparam logic [1:0] SPLIT_NONE = 2'd0;
  localparam logic [1:0] SPLIT_ONE  = 2'd1;
  localparam logic [1:0] SPLIT_TWO  = 2'd2;

  // Cascade limits
  localparam logic [6:0] HUNDREDTHS_MAX = 7'd99;
  localparam logic [5:0] SECONDS_MAX    = 6'd59;
  localparam logic [5:0] MINUTES_MAX    = 6'd59;

  // Stream widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

endpackage

// File: hw/rtl/stopwatch_with_splits.sv
// Channel  Ports                       Bits in tdata (lowest first)
// -------  --------------------------  -----------------------------------------------
// input    s_tvalid s_tready s_tdata   tick_event[0] joystick_code[5:1] zero[7:6]
// result   m_tvalid m_tready m_tdata   hours[7:0] minutes[13:8] seconds[19:14]
//                                      hundredths[26:20] running[27]
//                                      split_taken[29:28] zero[31:30]
//
// One item per cycle unless stalled: the time state and the result register update in the
// transfer cycle; the result shows in the cycle after. One input item gives one result.
// Reset (rst, synchronous) clears the time, sets running and empties the result register.
// A stalled result holds; a new item is taken in the cycle the held result is taken.
module stopwatch_with_splits (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // tick_event[0], joystick_code[5:1], zero pad[7:6]
  input  logic [sws_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // hours[7:0], minutes[13:8], seconds[19:14], hundredths[26:20],
  // running[27], split_taken[29:28], zero pad[31:30]
  output logic [sws_pkg::OUT_DATA_W-1:0]  m_tdata
);

  // State
  logic [6:0] hundredth_count;
  logic [5:0] second_count;
  logic [5:0] minute_count;
  logic [7:0] hour_count;
  logic       run_flag;
  logic [4:0] previous_joystick;
  logic       tick_pending;

  logic [6:0] hundredth_count_next;
  logic [5:0] second_count_next;
  logic [5:0] minute_count_next;
  logic [7:0] hour_count_next;
  logic       run_flag_next;
  logic [4:0] previous_joystick_next;
  logic       tick_pending_next;
  logic [1:0] split_next;

  logic       tick_event;
  logic [4:0] joystick_code;
  logic       in_xfer;

  // Result register
  logic       res_valid;
  logic [7:0] res_hours;
  logic [5:0] res_minutes;
  logic [5:0] res_seconds;
  logic [6:0] res_hundredths;
  logic       res_running;
  logic [1:0] res_split;

  assign tick_event    = s_tdata[0];
  assign joystick_code = s_tdata[5:1];
  assign s_tready      = !res_valid || m_tready;
  assign in_xfer       = s_tvalid && s_tready;

  // Tick, cascade, then joystick action
  always_comb begin
    logic pend;
    logic carry_s;
    logic carry_m;
    logic carry_h;
    pend                   = tick_pending || tick_event;
    hundredth_count_next   = hundredth_count;
    second_count_next      = second_count;
    minute_count_next      = minute_count;
    hour_count_next        = hour_count;
    run_flag_next          = run_flag;
    previous_joystick_next = previous_joystick;
    tick_pending_next      = pend;
    split_next             = sws_pkg::SPLIT_NONE;
    carry_s                = 1'b0;
    carry_m                = 1'b0;
    carry_h                = 1'b0;

    if (pend && run_flag) begin
      tick_pending_next = 1'b0;
      carry_s = (hundredth_count >= sws_pkg::HUNDREDTHS_MAX);
      carry_m = carry_s && (second_count >= sws_pkg::SECONDS_MAX);
      carry_h = carry_m && (minute_count >= sws_pkg::MINUTES_MAX);
      hundredth_count_next = carry_s ? 7'd0 : hundredth_count + 7'd1;
      if (carry_s) begin
        second_count_next = carry_m ? 6'd0 : second_count + 6'd1;
      end
      if (carry_m) begin
        minute_count_next = carry_h ? 6'd0 : minute_count + 6'd1;
      end
      if (carry_h) begin
        hour_count_next = hour_count + 8'd1;
      end
    end

    if (joystick_code != previous_joystick) begin
      previous_joystick_next = joystick_code;
      case (joystick_code)
        sws_pkg::JOY_CENTRE: begin
          run_flag_next = !run_flag;
        end
        sws_pkg::JOY_LEFT: begin
          if (run_flag) split_next = sws_pkg::SPLIT_ONE;
        end
        sws_pkg::JOY_RIGHT: begin
          if (run_flag) split_next = sws_pkg::SPLIT_TWO;
        end
        sws_pkg::JOY_DOWN: begin
          hundredth_count_next = 7'd0;
          second_count_next    = 6'd0;
          minute_count_next    = 6'd0;
          hour_count_next      = 8'd0;
        end
        default: begin
        end
      endcase
    end
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hundredth_count   <= '0;
      second_count      <= '0;
      minute_count      <= '0;
      hour_count        <= '0;
      run_flag          <= 1'b1;
      previous_joystick <= '0;
      tick_pending      <= 1'b0;
      res_valid         <= 1'b0;
    end else begin
      if (in_xfer) begin
        hundredth_count   <= hundredth_count_next;
        second_count      <= second_count_next;
        minute_count      <= minute_count_next;
        hour_count        <= hour_count_next;
        run_flag          <= run_flag_next;
        previous_joystick <= previous_joystick_next;
        tick_pending      <= tick_pending_next;
        res_valid         <= 1'b1;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_hours      <= hour_count_next;
      res_minutes    <= minute_count_next;
      res_seconds    <= second_count_next;
      res_hundredths <= hundredth_count_next;
      res_running    <= run_flag_next;
      res_split      <= split_next;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {2'b00, res_split, res_running, res_hundredths,
                     res_seconds, res_minutes, res_hours};

  // Checks
  a_split_needs_run: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_split != sws_pkg::SPLIT_NONE) |-> res_running)
    else $error("split reported while paused");

  a_split_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res_split == sws_pkg::SPLIT_NONE || res_split == sws_pkg::SPLIT_ONE
                  || res_split == sws_pkg::SPLIT_TWO))
    else $error("bad split code");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    (hundredth_count <= sws_pkg::HUNDREDTHS_MAX) && (second_count <= sws_pkg::SECONDS_MAX)
    && (minute_count <= sws_pkg::MINUTES_MAX))
    else $error("time count out of range");

  a_xfer_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> m_tvalid)
    else $error("transfer without result");

endmodule
